FILE: design/spri_pkg.sv
// shared types, register codes and index helpers for the sp register interface
package spri_pkg;

	localparam int IDX_W             = 11;
	localparam int DATA_W            = 32;
	localparam int MEM_WORDS_DEF     = 2048;
	localparam int PC_AREA_WORDS_DEF = 2;
	localparam int MEM_IDX_MAX_W     = 12;
	localparam int PC_IDX_MAX_W      = 3;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] SPACE_CTRL = 2'd0;
	localparam logic [1:0] SPACE_MEM  = 2'd1;
	localparam logic [1:0] SPACE_PC   = 2'd2;

	localparam logic [2:0] REG_MEM_ADDR  = 3'd0;
	localparam logic [2:0] REG_DRAM_ADDR = 3'd1;
	localparam logic [2:0] REG_RD_LEN    = 3'd2;
	localparam logic [2:0] REG_WR_LEN    = 3'd3;
	localparam logic [2:0] REG_STATUS    = 3'd4;
	localparam logic [2:0] REG_DMA_FULL  = 3'd5;
	localparam logic [2:0] REG_DMA_BUSY  = 3'd6;
	localparam logic [2:0] REG_SEMAPHORE = 3'd7;

	// status register bit positions
	localparam int STATUS_W    = 15;
	localparam int ST_HALT     = 0;
	localparam int ST_BROKE    = 1;
	localparam int ST_SSTEP    = 5;
	localparam int ST_INTBREAK = 6;
	localparam int ST_SIG0     = 7;
	localparam int NUM_SIGNALS = 8;

	// status write request bit positions
	localparam int RQ_CLR_HALT   = 0;
	localparam int RQ_SET_HALT   = 1;
	localparam int RQ_CLR_BROKE  = 2;
	localparam int RQ_CLR_INT    = 3;
	localparam int RQ_SET_INT    = 4;
	localparam int RQ_CLR_SSTEP  = 5;
	localparam int RQ_SET_SSTEP  = 6;
	localparam int RQ_CLR_INTBRK = 7;
	localparam int RQ_SET_INTBRK = 8;
	localparam int RQ_CLR_SIG0   = 9;
	localparam int RQ_SET_SIG0   = 10;

	typedef struct packed {
		logic              opcode;
		logic [1:0]        space;
		logic [IDX_W-1:0]  word_index;
		logic [DATA_W-1:0] write_data;
		logic [DATA_W-1:0] byte_mask;
	} in_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              start_task;
		logic              dma_in_start;
		logic              dma_out_start;
		logic              int_set;
		logic              int_clear;
	} out_beat_t;

	// index modulo a memory depth of at least 256 words: quotient stays below 8
	function automatic logic [MEM_IDX_MAX_W-1:0] mem_index(input logic [IDX_W-1:0] idx,
		input int m);
		int r;
		r = int'(idx);
		for (int k = 1; k <= 8; k++) begin
			if (int'(idx) >= k * m)
				r = int'(idx) - k * m;
		end
		return MEM_IDX_MAX_W'(r);
	endfunction

	// index modulo a small depth: sum of per-bit residues, then one reduction
	function automatic logic [PC_IDX_MAX_W-1:0] pc_index(input logic [IDX_W-1:0] idx,
		input int m);
		int w;
		int s;
		int r;
		s = 0;
		w = (m == 1) ? 0 : 1;
		for (int i = 0; i < IDX_W; i++) begin
			if (idx[i])
				s = s + w;
			w = 2 * w;
			if (w >= m)
				w = w - m;
		end
		r = s;
		for (int k = 1; k <= IDX_W; k++) begin
			if (s >= k * m)
				r = s - k * m;
		end
		return PC_IDX_MAX_W'(r);
	endfunction

endpackage

FILE: design/spri_ctrl.sv
// control register file with status set/clear logic, semaphore and dma start pulses
module spri_ctrl import spri_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      commit,
	input  in_beat_t  beat,
	output out_beat_t res
);

	logic [DATA_W-1:0]   mem_addr_q;
	logic [DATA_W-1:0]   dram_addr_q;
	logic [DATA_W-1:0]   rd_len_q;
	logic [DATA_W-1:0]   wr_len_q;
	logic [STATUS_W-1:0] status_q;
	logic                sema_q;

	logic [2:0]          reg_sel;
	logic                is_ctrl;
	logic                is_wr;
	logic [DATA_W-1:0]   w;
	logic [DATA_W-1:0]   cur;
	logic [DATA_W-1:0]   merged;
	logic [STATUS_W-1:0] status_nxt;

	assign reg_sel = beat.word_index[2:0];
	assign is_ctrl = (beat.space == SPACE_CTRL);
	assign is_wr   = (beat.opcode == OP_WRITE);
	assign w       = beat.write_data & beat.byte_mask;
	assign merged  = (cur & ~beat.byte_mask) | (beat.write_data & beat.byte_mask);

	always_comb begin
		case (reg_sel)
			REG_MEM_ADDR:  cur = mem_addr_q;
			REG_DRAM_ADDR: cur = dram_addr_q;
			REG_RD_LEN:    cur = rd_len_q;
			REG_WR_LEN:    cur = wr_len_q;
			REG_STATUS:    cur = {{(DATA_W-STATUS_W){1'b0}}, status_q};
			REG_SEMAPHORE: cur = {{(DATA_W-1){1'b0}}, sema_q};
			default:       cur = '0;
		endcase
	end

	// clear first, then set, so a set wins
	always_comb begin
		status_nxt = status_q;
		if (w[RQ_CLR_HALT])   status_nxt[ST_HALT] = 1'b0;
		if (w[RQ_SET_HALT])   status_nxt[ST_HALT] = 1'b1;
		if (w[RQ_CLR_BROKE])  status_nxt[ST_BROKE] = 1'b0;
		if (w[RQ_CLR_SSTEP])  status_nxt[ST_SSTEP] = 1'b0;
		if (w[RQ_SET_SSTEP])  status_nxt[ST_SSTEP] = 1'b1;
		if (w[RQ_CLR_INTBRK]) status_nxt[ST_INTBREAK] = 1'b0;
		if (w[RQ_SET_INTBRK]) status_nxt[ST_INTBREAK] = 1'b1;
		for (int n = 0; n < NUM_SIGNALS; n++) begin
			if (w[RQ_CLR_SIG0 + 2*n]) status_nxt[ST_SIG0 + n] = 1'b0;
			if (w[RQ_SET_SIG0 + 2*n]) status_nxt[ST_SIG0 + n] = 1'b1;
		end
	end

	always_comb begin
		res = '0;
		if (is_ctrl) begin
			if (!is_wr) begin
				res.read_data = cur;
			end else begin
				case (reg_sel)
					REG_STATUS: begin
						res.start_task = (w[RQ_CLR_HALT] || w[RQ_CLR_BROKE]) &&
							!status_nxt[ST_HALT] && !status_nxt[ST_BROKE];
						res.int_clear  = w[RQ_CLR_INT];
						res.int_set    = w[RQ_SET_INT];
					end
					REG_RD_LEN: res.dma_in_start = 1'b1;
					REG_WR_LEN: res.dma_out_start = 1'b1;
					default:    res = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_addr_q  <= '0;
			dram_addr_q <= '0;
			rd_len_q    <= '0;
			wr_len_q    <= '0;
			status_q    <= STATUS_W'(1) << ST_HALT;
			sema_q      <= 1'b0;
		end else if (commit && is_ctrl) begin
			if (!is_wr) begin
				if (reg_sel == REG_SEMAPHORE)
					sema_q <= 1'b1;
			end else begin
				case (reg_sel)
					REG_MEM_ADDR:  mem_addr_q  <= merged;
					REG_DRAM_ADDR: dram_addr_q <= merged;
					REG_RD_LEN:    rd_len_q    <= merged;
					REG_WR_LEN:    wr_len_q    <= merged;
					REG_STATUS:    status_q    <= status_nxt;
					REG_SEMAPHORE: sema_q      <= 1'b0;
					default:       sema_q      <= sema_q;
				endcase
			end
		end
	end

endmodule

FILE: design/spri_pc_area.sv
// program counter area: small register array with masked writes
module spri_pc_area import spri_pkg::*; #(
	parameter int PC_AREA_WORDS = PC_AREA_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  in_beat_t          beat,
	output logic [DATA_W-1:0] rd_data
);

	localparam int PW = (PC_AREA_WORDS > 1) ? $clog2(PC_AREA_WORDS) : 1;

	logic [DATA_W-1:0]       pc_q [PC_AREA_WORDS];
	logic [PC_IDX_MAX_W-1:0] idx_full;
	logic [PW-1:0]           idx;
	logic                    wr_en;

	assign idx_full = pc_index(beat.word_index, PC_AREA_WORDS);
	assign idx      = idx_full[PW-1:0];
	assign wr_en    = commit && (beat.space == SPACE_PC) && (beat.opcode == OP_WRITE);
	assign rd_data  = pc_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PC_AREA_WORDS; i++)
				pc_q[i] <= '0;
		end else if (wr_en) begin
			pc_q[idx] <= (pc_q[idx] & ~beat.byte_mask) | (beat.write_data & beat.byte_mask);
		end
	end

endmodule

FILE: design/spri_lmem.sv
// local data/instruction memory, bit-masked write port and registered read
module spri_lmem import spri_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic              clk,
	input  logic              commit,
	input  in_beat_t          beat,
	output logic [DATA_W-1:0] rd_data
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [DATA_W-1:0]        mem [MEM_WORDS];
	logic [DATA_W-1:0]        rd_q;
	logic [MEM_IDX_MAX_W-1:0] addr_full;
	logic [AW-1:0]            addr;
	logic                     is_mem;
	logic                     wr_en;
	logic                     rd_en;

	assign addr_full = mem_index(beat.word_index, MEM_WORDS);
	assign addr      = addr_full[AW-1:0];
	assign is_mem    = commit && (beat.space == SPACE_MEM);
	assign wr_en     = is_mem && (beat.opcode == OP_WRITE);
	assign rd_en     = is_mem && (beat.opcode == OP_READ);
	assign rd_data   = rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int b = 0; b < DATA_W; b++) begin
				if (beat.byte_mask[b])
					mem[addr][b] <= beat.write_data[b];
			end
		end
		if (rd_en)
			rd_q <= mem[addr];
	end

endmodule

FILE: design/signal_processor_register_interface.sv
// path: a request beat is registered in the request register, then in the response register
// throughput: one access per cycle while rsp_stall is low; request register feeds the response register
// stalled responses hold; one more request waits in the request register
// reset: arst_n clears both stage valids, the control registers (status halted)
// and the pc area; local memory has no clearing pass and is undefined until written
module signal_processor_register_interface import spri_pkg::*; #(
	parameter int MEM_WORDS     = MEM_WORDS_DEF,
	parameter int PC_AREA_WORDS = PC_AREA_WORDS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_beat_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_beat_t rsp
);

	// stage 1: registered request beat
	logic      valid_s1;
	in_beat_t  beat_s1;

	// stage 2: registered response beat
	logic      valid_s2;
	out_beat_t res_s2;
	logic      mem_sel_s2;   // read data comes from the memory read register

	logic              adv_s2;   // response register can take a new beat
	logic              commit;   // stage 1 beat executes and moves on
	logic              accept;
	out_beat_t         ctrl_res;
	out_beat_t         res_comb;
	logic [DATA_W-1:0] pc_rd;
	logic [DATA_W-1:0] mem_rd;

	assign adv_s2    = !valid_s2 || !rsp_stall;
	assign commit    = valid_s1 && adv_s2;
	// hold off a new request only while stage 1 is full and cannot move
	assign req_stall = valid_s1 && !adv_s2;
	assign accept    = req_valid && !req_stall;

	// control register file: read mux, status requests, pulses
	spri_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.beat   (beat_s1),
		.res    (ctrl_res)
	);

	spri_pc_area #(
		.PC_AREA_WORDS (PC_AREA_WORDS)
	) u_pc (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.beat    (beat_s1),
		.rd_data (pc_rd)
	);

	// memory read lands in its own register at the same edge as res_s2
	spri_lmem #(
		.MEM_WORDS (MEM_WORDS)
	) u_lmem (
		.clk     (clk),
		.commit  (commit),
		.beat    (beat_s1),
		.rd_data (mem_rd)
	);

	// ctrl result is all zero outside the control space
	always_comb begin
		res_comb = ctrl_res;
		if (beat_s1.space == SPACE_PC && beat_s1.opcode == OP_READ)
			res_comb.read_data = pc_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (commit)
				valid_s1 <= 1'b0;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			beat_s1 <= req;
		if (commit) begin
			res_s2     <= res_comb;
			mem_sel_s2 <= (beat_s1.space == SPACE_MEM) && (beat_s1.opcode == OP_READ);
		end
	end

	assign rsp_valid = valid_s2;

	always_comb begin
		rsp = res_s2;
		if (mem_sel_s2)
			rsp.read_data = mem_rd;
	end

endmodule

FILE: design/spri_checker.sv
// port-level checks for the sp register interface, bound to the top level
module spri_props import spri_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input in_beat_t  req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input out_beat_t rsp
);

	// every accepted request is checked for a response beat once it has passed the request and response registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> ##1 rsp_valid)
		else $error("no response two cycles after accepted request");

	// pulses only come from writes, and writes read back zero
	a_pulse_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.start_task || rsp.dma_in_start || rsp.dma_out_start ||
		rsp.int_set || rsp.int_clear) |-> rsp.read_data == '0)
		else $error("pulse beat carries read data");

	// dma pulses come from the length registers, never with status pulses
	a_dma_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.dma_in_start || rsp.dma_out_start) |->
		!(rsp.dma_in_start && rsp.dma_out_start) && !rsp.start_task &&
		!rsp.int_set && !rsp.int_clear)
		else $error("dma pulse mixed with other pulses");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response beat changed");

endmodule

bind signal_processor_register_interface spri_props u_spri_props (.*);
